### rtl/irfe_pkg.sv
// Shared types, widths and timing constants for the IR remote frame encoder.
// No dependencies; imported by every module of the block.
package irfe_pkg;

    localparam int ADDRESS_BITS_DEF = 13;
    localparam int COMMAND_BITS_DEF = 8;

    localparam int ADDR_REG_W  = 13;
    localparam int CMD_IN_W    = 8;
    localparam int PULSE_W     = 14;
    localparam int SPACE_W     = 13;
    localparam int ELAPSED_W   = 17;
    localparam int OUT_TDATA_W = 48;

    localparam logic [PULSE_W-1:0] HDR_PULSE   = 14'd8800;
    localparam logic [SPACE_W-1:0] HDR_SPACE   = 13'd4400;
    localparam logic [PULSE_W-1:0] RPT_PULSE   = 14'd8800;
    localparam logic [SPACE_W-1:0] RPT_SPACE   = 13'd2250;
    localparam logic [PULSE_W-1:0] BIT_PULSE   = 14'd550;
    localparam logic [SPACE_W-1:0] ZERO_SPACE  = 13'd550;
    localparam logic [SPACE_W-1:0] ONE_SPACE   = 13'd1650;
    localparam logic [PULSE_W-1:0] TRAIL_PULSE = 14'd550;
    localparam logic [SPACE_W-1:0] TRAIL_SPACE = 13'd0;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // kind of pulse/space pair emitted in a cycle
    typedef enum logic [2:0] {
        ELEM_HDR   = 3'd0,
        ELEM_RPT   = 3'd1,
        ELEM_ABIT  = 3'd2,
        ELEM_AINV  = 3'd3,
        ELEM_CBIT  = 3'd4,
        ELEM_CINV  = 3'd5,
        ELEM_TRAIL = 3'd6
    } elem_t;

    typedef struct packed {
        logic  load;           // input transaction taken
        logic  emit;           // load one pair into the output register
        elem_t elem;
        logic  cnt_load_addr;  // restart bit counter for an address run
        logic  cnt_load_cmd;   // restart bit counter for a command run
    } irfe_cmd_t;

    typedef struct packed {
        logic out_free;
        logic cnt_zero;
        logic mode;
    } irfe_status_t;

    function automatic logic [PULSE_W-1:0] elem_pulse(elem_t elem);
        logic [PULSE_W-1:0] p;
        case (elem)
            ELEM_HDR:   p = HDR_PULSE;
            ELEM_RPT:   p = RPT_PULSE;
            ELEM_TRAIL: p = TRAIL_PULSE;
            default:    p = BIT_PULSE;
        endcase
        return p;
    endfunction

    function automatic logic [SPACE_W-1:0] elem_space(elem_t elem, logic bit_val);
        logic [SPACE_W-1:0] s;
        case (elem)
            ELEM_HDR:   s = HDR_SPACE;
            ELEM_RPT:   s = RPT_SPACE;
            ELEM_TRAIL: s = TRAIL_SPACE;
            default:    s = bit_val ? ONE_SPACE : ZERO_SPACE;
        endcase
        return s;
    endfunction

endpackage

### rtl/irfe_ctrl.sv
// Frame sequencer: walks header, address, inverted address, command,
// inverted command and trailer phases; a repeat goes from header to trailer. Depends on irfe_pkg.
module irfe_ctrl import irfe_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  irfe_status_t status,
    output irfe_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_HDR      = 7'b0000010,
        ST_ADDR     = 7'b0000100,
        ST_ADDR_INV = 7'b0001000,
        ST_CMD      = 7'b0010000,
        ST_CMD_INV  = 7'b0100000,
        ST_TRAIL    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.elem = ELEM_TRAIL;
        cmd.load = s_tvalid && (state_reg == ST_IDLE);
        cmd.emit = (state_reg != ST_IDLE) && status.out_free;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) state_next = ST_HDR;
            end
            ST_HDR: begin
                cmd.elem = status.mode ? ELEM_RPT : ELEM_HDR;
                if (cmd.emit) begin
                    if (status.mode) begin
                        state_next = ST_TRAIL;
                    end else begin
                        cmd.cnt_load_addr = 1'b1;
                        state_next = ST_ADDR;
                    end
                end
            end
            ST_ADDR: begin
                cmd.elem = ELEM_ABIT;
                if (cmd.emit && status.cnt_zero) begin
                    cmd.cnt_load_addr = 1'b1;
                    state_next = ST_ADDR_INV;
                end
            end
            ST_ADDR_INV: begin
                cmd.elem = ELEM_AINV;
                if (cmd.emit && status.cnt_zero) begin
                    cmd.cnt_load_cmd = 1'b1;
                    state_next = ST_CMD;
                end
            end
            ST_CMD: begin
                cmd.elem = ELEM_CBIT;
                if (cmd.emit && status.cnt_zero) begin
                    cmd.cnt_load_cmd = 1'b1;
                    state_next = ST_CMD_INV;
                end
            end
            ST_CMD_INV: begin
                cmd.elem = ELEM_CINV;
                if (cmd.emit && status.cnt_zero) state_next = ST_TRAIL;
            end
            ST_TRAIL: begin
                cmd.elem = ELEM_TRAIL;
                if (cmd.emit) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

### rtl/irfe_datapath.sv
// Datapath: address register, bit shifters, bit counter, elapsed
// accumulator and output register. Depends on irfe_pkg.
module irfe_datapath import irfe_pkg::*; #(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
    parameter int COMMAND_BITS = COMMAND_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [ADDR_REG_W-1:0]  cfg_wdata,
    input  logic [CMD_IN_W-1:0]    s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    input  irfe_cmd_t              cmd,
    output irfe_status_t           status
);

    localparam int MAX_BITS  = (ADDRESS_BITS > COMMAND_BITS) ? ADDRESS_BITS : COMMAND_BITS;
    localparam int CNT_W     = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
    localparam int ADDR_EXT_W = (ADDRESS_BITS > ADDR_REG_W) ? ADDRESS_BITS : ADDR_REG_W;
    localparam int CMD_EXT_W  = (COMMAND_BITS > CMD_IN_W) ? COMMAND_BITS : CMD_IN_W;
    localparam logic [CNT_W-1:0] ADDR_LAST = CNT_W'(ADDRESS_BITS - 1);
    localparam logic [CNT_W-1:0] CMD_LAST  = CNT_W'(COMMAND_BITS - 1);
    localparam int PAD_W = OUT_TDATA_W - ELAPSED_W - SPACE_W - PULSE_W;

    logic [ADDR_REG_W-1:0]   address_reg;
    logic [ADDRESS_BITS-1:0] addr_sh_reg;
    logic [COMMAND_BITS-1:0] cmd_sh_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    mode_reg;
    logic [ELAPSED_W-1:0]    elapsed_reg;
    logic                    m_tvalid_reg;
    logic [PULSE_W-1:0]      m_pulse_reg;
    logic [SPACE_W-1:0]      m_space_reg;
    logic [ELAPSED_W-1:0]    m_elapsed_reg;
    logic                    m_tlast_reg;

    logic [ADDR_EXT_W-1:0]   addr_ext;
    logic [CMD_EXT_W-1:0]    cmd_ext;
    logic                    bit_val;
    logic                    addr_phase;
    logic                    cmd_phase;
    logic [PULSE_W-1:0]      pulse;
    logic [SPACE_W-1:0]      space;
    logic [ELAPSED_W:0]      sum;
    logic [ELAPSED_W-1:0]    elapsed_next;

    // zero-extend or truncate to the frame's field widths
    assign addr_ext = ADDR_EXT_W'(address_reg);
    assign cmd_ext  = CMD_EXT_W'(s_tdata);

    always_comb begin
        addr_phase = cmd.elem inside {ELEM_ABIT, ELEM_AINV};
        cmd_phase  = cmd.elem inside {ELEM_CBIT, ELEM_CINV};
        case (cmd.elem)
            ELEM_ABIT: bit_val = addr_sh_reg[0];
            ELEM_AINV: bit_val = ~addr_sh_reg[0];
            ELEM_CBIT: bit_val = cmd_sh_reg[0];
            ELEM_CINV: bit_val = ~cmd_sh_reg[0];
            default:   bit_val = 1'b0;
        endcase
        pulse = elem_pulse(cmd.elem);
        space = elem_space(cmd.elem, bit_val);
        sum = {1'b0, elapsed_reg} + (ELAPSED_W+1)'(pulse) + (ELAPSED_W+1)'(space);
        elapsed_next = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            address_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) address_reg <= cfg_wdata;
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_sh_reg <= addr_ext[ADDRESS_BITS-1:0];
            cmd_sh_reg  <= cmd_ext[COMMAND_BITS-1:0];
            mode_reg    <= s_tuser;
            elapsed_reg <= '0;
        end else if (cmd.emit) begin
            elapsed_reg <= elapsed_next;
            // rotate so the same bits come round again for the inverted copy
            if (addr_phase) addr_sh_reg <= (addr_sh_reg >> 1) | (addr_sh_reg << (ADDRESS_BITS - 1));
            if (cmd_phase)  cmd_sh_reg  <= (cmd_sh_reg >> 1) | (cmd_sh_reg << (COMMAND_BITS - 1));
        end

        if (cmd.cnt_load_addr) begin
            cnt_reg <= ADDR_LAST;
        end else if (cmd.cnt_load_cmd) begin
            cnt_reg <= CMD_LAST;
        end else if (cmd.emit && (addr_phase || cmd_phase)) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end

        if (cmd.emit) begin
            m_pulse_reg   <= pulse;
            m_space_reg   <= space;
            m_elapsed_reg <= elapsed_next;
            m_tlast_reg   <= (cmd.elem == ELEM_TRAIL);
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.mode     = mode_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_elapsed_reg, m_space_reg, m_pulse_reg};
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/ir_remote_frame_encoder.sv
// Start: the input transaction moves the sequencer out of idle, and the first pair is then
// loaded into the output register. Throughput: one pair per cycle while the output is not
// stalled, so a full frame is 2*(ADDRESS_BITS+COMMAND_BITS)+2 pairs per input (44 pairs at
// defaults) and a repeat block 2 pairs; the sequencer then returns to idle to take the next
// transaction. Output stalls hold the sequencer.
// Reset: aresetn synchronous active low; clears the address register to 0 and the sequencer.
module ir_remote_frame_encoder import irfe_pkg::*; #(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
    parameter int COMMAND_BITS = COMMAND_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [ADDR_REG_W-1:0]  cfg_wdata,    // address_code
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [CMD_IN_W-1:0]    s_tdata,      // [7:0] command_code
    input  logic                   s_tuser,      // [0] mode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,      // [13:0] pulse_us, [26:14] space_us,
                                                 // [43:27] elapsed_us, [47:44] zero
    output logic                   m_tlast       // last
);

    irfe_cmd_t    cmd;
    irfe_status_t status;

    irfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    irfe_datapath #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .COMMAND_BITS (COMMAND_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
